>>> rtl/brfb_pkg.sv
// ----------------------------------------------------------------------------
// brfb_pkg
// Shared types, constants and helpers for the byte ring FIFO with block access.
// ----------------------------------------------------------------------------
package brfb_pkg;

  localparam int unsigned MAX_DEPTH = 1024;
  localparam int unsigned MAX_BLOCK = 8;

  localparam int unsigned PTR_W  = $clog2(MAX_DEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned BYTE_W = 8;

  // Item modes as they arrive on the mode port.
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_STATUS = 2'd3;

  // Commands handed from the front end to the execution end.
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_CLEAR,
    CMD_REPORT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic               acc;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               pop;
    logic               acc;
    logic               last;
    logic [CNT_W-1:0]   fill;
  } res_t;

  // Clamp a written capacity into 1 .. MAX_DEPTH.
  function automatic logic [CNT_W-1:0] cap_eff(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(MAX_DEPTH)) r = CNT_W'(MAX_DEPTH);
    return r;
  endfunction

  // Step a ring pointer, wrapping at the capacity.
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/brfb_front.sv
// ----------------------------------------------------------------------------
// brfb_front
// Accepts items, checks them against a committed byte count and issues commands.
// ----------------------------------------------------------------------------
module brfb_front import brfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic [CNT_W-1:0]  cap_i,
  input  logic              accept_i,
  input  logic [1:0]        mode_i,
  input  logic [LEN_W-1:0]  block_length_i,
  input  logic [DATA_W-1:0] block_data_i,
  output cmd_t              cmd_o
);

  // Bytes stored once every issued command has been carried out.
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] free_cnt, len_ext;
  logic             len_ok, push_ok, pop_ok;

  always_comb begin
    free_cnt = cap_i - count_q;
    len_ext  = CNT_W'(block_length_i);
    len_ok   = (block_length_i != '0) && (block_length_i <= LEN_W'(MAX_BLOCK));
    push_ok  = (mode_i == MODE_PUSH) && len_ok && (len_ext <= free_cnt);
    pop_ok   = (mode_i == MODE_POP) && len_ok && (len_ext <= count_q);

    cmd_o.len  = block_length_i;
    cmd_o.data = block_data_i;
    cmd_o.acc  = 1'b1;
    count_d    = count_q;
    if (push_ok) begin
      cmd_o.op = CMD_PUSH;
      count_d  = count_q + len_ext;
    end else if (pop_ok) begin
      cmd_o.op = CMD_POP;
      count_d  = count_q - len_ext;
    end else if (mode_i == MODE_CLEAR) begin
      cmd_o.op = CMD_CLEAR;
      count_d  = '0;
    end else begin
      // Status query, or a refused push or pop.
      cmd_o.op  = CMD_REPORT;
      cmd_o.acc = (mode_i == MODE_STATUS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/brfb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// brfb_cmd_fifo
// Two-entry command queue between the front end and the execution end.
// ----------------------------------------------------------------------------
module brfb_cmd_fifo import brfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> rtl/brfb_back.sv
// ----------------------------------------------------------------------------
// brfb_back
// Executes commands on the single-port byte store, one byte per cycle.
// ----------------------------------------------------------------------------
module brfb_back import brfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic [CNT_W-1:0]  cap_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output res_t              res_o,
  output logic [BYTE_W-1:0] rd_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_POP
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] sh_q, sh_d;
  res_t              res_q, res_d;

  logic [BYTE_W-1:0] mem_q [MAX_DEPTH];
  logic [BYTE_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_addr;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    sh_d      = sh_q;
    res_d     = '0;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wp_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rem_d     = cmd_i.len;
          sh_d      = cmd_i.data;
          case (cmd_i.op)
            CMD_PUSH: state_d = S_PUSH;
            CMD_POP:  state_d = S_POP;
            CMD_CLEAR: begin
              wp_d       = '0;
              rp_d       = '0;
              cnt_d      = '0;
              res_d.valid = 1'b1;
              res_d.acc   = 1'b1;
              res_d.last  = 1'b1;
            end
            default: begin
              res_d.valid = 1'b1;
              res_d.acc   = cmd_i.acc;
              res_d.last  = 1'b1;
              res_d.fill  = cnt_q;
            end
          endcase
        end
      end
      S_PUSH: begin
        mem_we   = 1'b1;
        mem_addr = wp_q;
        wp_d     = ptr_adv(wp_q, cap_i);
        cnt_d    = cnt_q + CNT_W'(1);
        sh_d     = sh_q >> BYTE_W;
        rem_d    = rem_q - LEN_W'(1);
        if (rem_q == LEN_W'(1)) begin
          res_d.valid = 1'b1;
          res_d.acc   = 1'b1;
          res_d.last  = 1'b1;
          res_d.fill  = cnt_d;
          state_d     = S_IDLE;
        end
      end
      S_POP: begin
        mem_re      = 1'b1;
        mem_addr    = rp_q;
        rp_d        = ptr_adv(rp_q, cap_i);
        cnt_d       = cnt_q - CNT_W'(1);
        rem_d       = rem_q - LEN_W'(1);
        res_d.valid = 1'b1;
        res_d.pop   = 1'b1;
        res_d.acc   = 1'b1;
        res_d.fill  = cnt_d;
        res_d.last  = (rem_q == LEN_W'(1));
        if (rem_q == LEN_W'(1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // A capacity write empties the queue; idle-only use is up to the user.
    if (clear_i) begin
      wp_d  = '0;
      rp_d  = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= sh_q[BYTE_W-1:0];
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign res_o     = res_q;
  assign rd_data_o = (res_q.valid && res_q.pop) ? rd_q : '0;

endmodule

>>> rtl/byte_ring_fifo_block_access.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_access
// Byte ring-buffer FIFO with all-or-nothing block push and pop.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. A push of 1 to 8
// bytes is dispatched from the command queue and then written one byte at a
// time into the single-port byte store, and gives one result word when the
// last byte is written. A pop is dispatched likewise and then reads one byte
// at a time, and gives one result word per byte on consecutive cycles, the
// final one with last_o set. Clear, status and refused items give one word.
// A two-entry command queue lets up to two further items be taken while one
// is being carried out, and busy_o is high only while that queue is full.
// Result words are shown on done_o for exactly one cycle and cannot be held
// off by the receiver. A write on cfg_we_i sets the capacity (0 reads as 1,
// anything above 1024 as 1024) and empties the queue; it must only be issued
// while the block is idle. The byte store has no reset; only bytes written
// since the last clear are ever read.
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_access import brfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        mode_i,
  input  logic [LEN_W-1:0]  block_length_i,
  input  logic [DATA_W-1:0] block_data_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  output logic              done_o,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic              accepted_o,
  output logic [CNT_W-1:0]  fill_count_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic              is_empty_o,
  output logic              last_o
);

  // The capacity is held already clamped into its legal range.
  logic [CNT_W-1:0] cap_q;
  logic             accept;
  logic             q_full, q_valid, q_pop;
  cmd_t             front_cmd, back_cmd;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(MAX_DEPTH);
    end else if (cfg_we_i) begin
      cap_q <= cap_eff(cfg_wdata_i);
    end
  end

  assign busy_o = q_full;
  assign accept = start_i && !q_full;

  brfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (cfg_we_i),
    .cap_i          (cap_q),
    .accept_i       (accept),
    .mode_i         (mode_i),
    .block_length_i (block_length_i),
    .block_data_i   (block_data_i),
    .cmd_o          (front_cmd)
  );

  brfb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (back_cmd)
  );

  brfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we_i),
    .cap_i       (cap_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .res_o       (res),
    .rd_data_o   (data_byte_o)
  );

  // The fill count never exceeds the capacity, so the difference is exact.
  assign done_o       = res.valid;
  assign accepted_o   = res.acc;
  assign fill_count_o = res.fill;
  assign free_count_o = cap_q - res.fill;
  assign is_empty_o   = (res.fill == '0);
  assign last_o       = res.last;

endmodule

>>> rtl/brfb_checker.sv
// ----------------------------------------------------------------------------
// brfb_checker
// Port-level checks on the result words of the byte ring FIFO.
// ----------------------------------------------------------------------------
module brfb_checker import brfb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              done_o,
  input logic [BYTE_W-1:0] data_byte_o,
  input logic              accepted_o,
  input logic [CNT_W-1:0]  fill_count_o,
  input logic [CNT_W-1:0]  free_count_o,
  input logic              last_o
);

  // A refused item gives a single word with no byte.
  a_refused_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !accepted_o |-> last_o && (data_byte_o == '0))
    else $error("refused item did not give a single empty word");

  // The bytes of one pop follow on back to back, each one taking a byte off.
  a_pop_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o && accepted_o
      && (fill_count_o == $past(fill_count_o) - CNT_W'(1)))
    else $error("pop burst broken or fill count not stepping down");

  // Fill and free always add up to a legal capacity.
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (CNT_W'(fill_count_o + free_count_o) != '0)
      && (CNT_W'(fill_count_o + free_count_o) <= CNT_W'(MAX_DEPTH)))
    else $error("fill plus free outside the capacity range");

  // Between capacity writes the capacity seen on the ports does not move.
  a_cap_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && !$past(cfg_we_i) |->
      (fill_count_o + free_count_o) == ($past(fill_count_o) + $past(free_count_o)))
    else $error("capacity changed without a configuration write");

endmodule

bind byte_ring_fifo_block_access brfb_checker u_brfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .done_o       (done_o),
  .data_byte_o  (data_byte_o),
  .accepted_o   (accepted_o),
  .fill_count_o (fill_count_o),
  .free_count_o (free_count_o),
  .last_o       (last_o)
);
